>>> design/nkvgf_pkg.sv
`default_nettype none
package nkvgf_pkg;

    localparam int MAX_MARKERS = 4096;
    localparam int IDX_W       = $clog2(MAX_MARKERS);
    localparam int CNT_W       = $clog2(MAX_MARKERS + 1);
    localparam int POS_W       = 28;
    localparam int CM_W        = 25;
    localparam int DIST_W      = POS_W + 1;
    localparam int OP_W        = 2;
    localparam int IN_DATA_W   = 72;
    localparam int OUT_DATA_W  = 32;

    localparam logic [POS_W-1:0] WINDOW_RESET = POS_W'(100000);

    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

    typedef struct packed {
        logic            known;
        logic [CM_W-1:0] value;
        logic [POS_W-1:0] pos;
    } t_marker;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_QCHK   = 7'b0000010,
        S_LCHK   = 7'b0000100,
        S_RSTART = 7'b0001000,
        S_RCHK   = 7'b0010000,
        S_RES    = 7'b0100000,
        S_OUT    = 7'b1000000
    } t_state;

endpackage
`default_nettype wire

>>> design/nearest_known_value_gap_fill_unit.sv
`default_nettype none
// Marker table with nearest-known-value fill. Each input beat carries an
// operation in tuser: clear and append finish in the cycle they are taken
// and give no result; a query gives one result beat. A known marker is
// returned without a scan, and an index past the marker count gives an
// index error without a table lookup. A query of a missing marker walks
// the single read port of the marker memory one neighbor per cycle, left
// and then right, until a known marker, the window edge or the table
// end stops that side. The block takes no new beat until the result is
// loaded into the output register, so a result held back by the sink
// also holds back the next beat.
// The window register may be written whenever the block is idle.
module nearest_known_value_gap_fill_unit (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              s_axis_tvalid,
    output logic                             s_axis_tready,
    // position[27:0], cm_in[52:28], cm_in_known[53], query_index[65:54], zero fill
    input  wire  [nkvgf_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // operation[1:0]
    input  wire  [nkvgf_pkg::OP_W-1:0]       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  wire                              m_axis_tready,
    // cm_out[24:0], zero fill
    output logic [nkvgf_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // cm_out_known[0], index_error[1]
    output logic [1:0]                       m_axis_tuser,
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire  [nkvgf_pkg::POS_W-1:0]      i_cfg_data
);
    import nkvgf_pkg::*;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [IDX_W-1:0]  r_addr, n_addr;
    logic [IDX_W-1:0]  r_q, n_q;
    logic [POS_W-1:0]  r_pos_q, n_pos_q;
    logic [POS_W-1:0]  r_win;
    logic              r_have_l, n_have_l, r_have_r, n_have_r;
    logic [CM_W-1:0]   r_val_l, n_val_l, r_val_r, n_val_r;
    logic [DIST_W-1:0] r_dist_l, n_dist_l, r_dist_r, n_dist_r;
    logic [CM_W-1:0]   r_res_val, n_res_val;
    logic              r_res_known, n_res_known, r_res_err, n_res_err;
    logic              r_m_valid;
    logic [CM_W-1:0]   r_m_val;
    logic              r_m_known, r_m_err;

    t_marker           r_mem [MAX_MARKERS];
    t_marker           r_rd;
    t_marker           w_wr;
    logic              w_we;

    logic              w_in_beat;
    logic [POS_W-1:0]  w_in_pos;
    logic [CM_W-1:0]   w_in_cm;
    logic              w_in_known;
    logic [IDX_W-1:0]  w_in_q;
    logic [DIST_W-1:0] w_dist;
    logic              w_out_win;
    logic              w_load_out;

    assign w_in_pos   = s_axis_tdata[POS_W-1:0];
    assign w_in_cm    = s_axis_tdata[POS_W +: CM_W];
    assign w_in_known = s_axis_tdata[POS_W+CM_W];
    assign w_in_q     = s_axis_tdata[POS_W+CM_W+1 +: IDX_W];

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_beat     = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign w_load_out    = (r_state == S_OUT) && (!r_m_valid || m_axis_tready);

    assign w_wr = '{known: w_in_known, value: w_in_cm, pos: w_in_pos};
    assign w_we = w_in_beat && (s_axis_tuser == OP_APPEND)
                  && (r_count < CNT_W'(MAX_MARKERS));

    // One subtractor serves both scan directions.
    always_comb begin
        if (r_state == S_LCHK) begin
            w_dist = {1'b0, r_pos_q} - {1'b0, r_rd.pos};
        end else begin
            w_dist = {1'b0, r_rd.pos} - {1'b0, r_pos_q};
        end
        w_out_win = $signed(w_dist) >= $signed({1'b0, r_win});
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_addr      = r_addr;
        n_q         = r_q;
        n_pos_q     = r_pos_q;
        n_have_l    = r_have_l;
        n_have_r    = r_have_r;
        n_val_l     = r_val_l;
        n_val_r     = r_val_r;
        n_dist_l    = r_dist_l;
        n_dist_r    = r_dist_r;
        n_res_val   = r_res_val;
        n_res_known = r_res_known;
        n_res_err   = r_res_err;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_beat) begin
                    unique case (s_axis_tuser)
                        OP_CLEAR:  n_count = '0;
                        OP_APPEND: begin
                            if (w_we) n_count = r_count + CNT_W'(1);
                        end
                        OP_QUERY: begin
                            n_q      = w_in_q;
                            n_addr   = w_in_q;
                            n_have_l = 1'b0;
                            n_have_r = 1'b0;
                            if ({1'b0, w_in_q} >= r_count) begin
                                n_res_val   = '0;
                                n_res_known = 1'b0;
                                n_res_err   = 1'b1;
                                n_state     = S_OUT;
                            end else begin
                                n_state = S_QCHK;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_QCHK: begin
                n_pos_q   = r_rd.pos;
                n_res_err = 1'b0;
                if (r_rd.known) begin
                    n_res_val   = r_rd.value;
                    n_res_known = 1'b1;
                    n_state     = S_OUT;
                end else if (r_q == '0) begin
                    n_state = S_RSTART;
                end else begin
                    n_addr  = r_q - IDX_W'(1);
                    n_state = S_LCHK;
                end
            end
            S_LCHK: begin
                if (w_out_win) begin
                    n_state = S_RSTART;
                end else if (r_rd.known) begin
                    n_have_l = 1'b1;
                    n_val_l  = r_rd.value;
                    n_dist_l = w_dist;
                    n_state  = S_RSTART;
                end else if (r_addr == '0) begin
                    n_state = S_RSTART;
                end else begin
                    n_addr = r_addr - IDX_W'(1);
                end
            end
            S_RSTART: begin
                if (({1'b0, r_q} + CNT_W'(1)) < r_count) begin
                    n_addr  = r_q + IDX_W'(1);
                    n_state = S_RCHK;
                end else begin
                    n_state = S_RES;
                end
            end
            S_RCHK: begin
                if (w_out_win) begin
                    n_state = S_RES;
                end else if (r_rd.known) begin
                    n_have_r = 1'b1;
                    n_val_r  = r_rd.value;
                    n_dist_r = w_dist;
                    n_state  = S_RES;
                end else if (({1'b0, r_addr} + CNT_W'(1)) >= r_count) begin
                    n_state = S_RES;
                end else begin
                    n_addr = r_addr + IDX_W'(1);
                end
            end
            S_RES: begin
                n_res_known = r_have_l || r_have_r;
                // A tie between the two sides goes to the right.
                if (r_have_l && (!r_have_r || $signed(r_dist_l) < $signed(r_dist_r))) begin
                    n_res_val = r_val_l;
                end else if (r_have_r) begin
                    n_res_val = r_val_r;
                end else begin
                    n_res_val = '0;
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (w_load_out) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[r_count[IDX_W-1:0]] <= w_wr;
        r_rd <= r_mem[n_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_win     <= WINDOW_RESET;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (i_cfg_valid && o_cfg_ready) r_win <= i_cfg_data;
            if (w_load_out) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr      <= n_addr;
        r_q         <= n_q;
        r_pos_q     <= n_pos_q;
        r_have_l    <= n_have_l;
        r_have_r    <= n_have_r;
        r_val_l     <= n_val_l;
        r_val_r     <= n_val_r;
        r_dist_l    <= n_dist_l;
        r_dist_r    <= n_dist_r;
        r_res_val   <= n_res_val;
        r_res_known <= n_res_known;
        r_res_err   <= n_res_err;
        if (w_load_out) begin
            r_m_val   <= r_res_val;
            r_m_known <= r_res_known;
            r_m_err   <= r_res_err;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = OUT_DATA_W'(r_m_val);
    assign m_axis_tuser  = {r_m_err, r_m_known};

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_MARKERS))
        else $error("marker count past table size");

    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |-> (!m_axis_tuser[0] && m_axis_tdata == '0))
        else $error("index error result carries a value");

    a_missing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0))
        else $error("missing result with nonzero value");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_beat && s_axis_tuser == OP_QUERY) |=> !s_axis_tready)
        else $error("new beat taken during a query");

endmodule
`default_nettype wire
